### hdl/vertex_cluster_simplifier_defines.svh
// Assertion macros for the vertex cluster simplifier.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef VERTEX_CLUSTER_SIMPLIFIER_DEFINES_SVH
`define VERTEX_CLUSTER_SIMPLIFIER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define VCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define VCS_ASSERT(lbl, clk, rst_n, prop)
`define VCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/vcs_pkg.sv
// Shared types and constants for the vertex cluster simplifier.
// No dependencies.
package vcs_pkg;

  localparam int COORD_W        = 32;
  localparam int AXIS_BITS_DEF  = 4;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_MIN_X   = 3'd0,
    REG_GRID_MIN_Y   = 3'd1,
    REG_GRID_MIN_Z   = 3'd2,
    REG_CELL_SCALE_X = 3'd3,
    REG_CELL_SCALE_Y = 3'd4,
    REG_CELL_SCALE_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_IDX   = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_CLOSE = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      interior_in;
    logic                      poly_first;
    logic                      poly_last;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rep_x;
    logic signed [COORD_W-1:0] rep_y;
    logic signed [COORD_W-1:0] rep_z;
    logic                      interior_out;
    logic                      polygon_end;
    logic                      run_last;
    logic                      cell_missing;
  } result_t;

endpackage

### hdl/vcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/vcs_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module vcs_divider #(
  parameter int DIVIDEND_W = 49,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  active_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d, dvs_q;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= active_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= CNT_W'(DIVIDEND_W);
      end else if (active_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/vertex_cluster_simplifier.sv
// Vertex clustering: an accumulate steps through the MUL, IDX and RD states before the next accept.
// A map also waits in DIV for the bit-serial mean dividers (COORD_W+COUNT_BITS+1
// quotient bits), then emits from OUT; an empty cell skips the dividers; a
// CLOSE state follows OUT when a closing copy follows an emitted vertex. Results
// are registered from OUT or CLOSE and cannot be stalled. After reset the cell RAM
// is cleared in CLEAR, all 2^(3*AXIS_BITS) cells (4096 at defaults).
`include "vertex_cluster_simplifier_defines.svh"
// Top level; uses vcs_pkg, vcs_ram and vcs_divider.
module vertex_cluster_simplifier #(
  parameter int AXIS_BITS  = vcs_pkg::AXIS_BITS_DEF,
  parameter int COUNT_BITS = vcs_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  vcs_pkg::item_t                   item_i,
  output logic                             result_valid_o,
  output vcs_pkg::result_t                 result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int CW      = vcs_pkg::COORD_W;
  localparam int CELL_W  = 3 * AXIS_BITS;
  localparam int NCELLS  = 1 << CELL_W;
  localparam int SUM_W   = CW + COUNT_BITS;
  localparam int DIVD_W  = SUM_W + 1;
  localparam int WORD_W  = 3 * SUM_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [AXIS_BITS-1:0]  AXIS_MAX  = '1;

  vcs_pkg::state_e state_q, state_d;
  vcs_pkg::item_t  in_q;
  vcs_pkg::result_t res_q;
  logic             res_vld_q;

  logic [CW-1:0]     gmin_q [3];
  logic [CW-1:0]     scale_q [3];
  logic [2*CW-1:0]   prod_q [3];
  logic [2:0]        dpos_q, neg_q;
  logic [CELL_W-1:0] cell_q, clr_q, cell_d;
  logic              missing_q;
  logic [CW-1:0]     rep_q [3];
  logic [CW-1:0]     last_q [3];
  logic [CW-1:0]     ring_q [3];
  logic              ring_open_q;

  logic [CW-1:0]     coord [3];
  logic [AXIS_BITS-1:0] idx [3];

  logic              ram_we, ram_re;
  logic [CELL_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [SUM_W-1:0]      sum_rd [3];
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [SUM_W-1:0]      mag [3];
  logic [DIVD_W-1:0]     divd [3];
  logic [DIVD_W-1:0]     quo [3];
  logic [2:0]            div_done;
  logic                  div_start;

  assign coord[0] = in_q.coord_x;
  assign coord[1] = in_q.coord_y;
  assign coord[2] = in_q.coord_z;

  assign busy        = (state_q != vcs_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        gmin_q[a]  <= '0;
        scale_q[a] <= vcs_pkg::SCALE_RESET;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vcs_pkg::REG_GRID_MIN_X:   gmin_q[0]  <= cfg_data_i;
        vcs_pkg::REG_GRID_MIN_Y:   gmin_q[1]  <= cfg_data_i;
        vcs_pkg::REG_GRID_MIN_Z:   gmin_q[2]  <= cfg_data_i;
        vcs_pkg::REG_CELL_SCALE_X: scale_q[0] <= cfg_data_i;
        vcs_pkg::REG_CELL_SCALE_Y: scale_q[1] <= cfg_data_i;
        vcs_pkg::REG_CELL_SCALE_Z: scale_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // axis index from the registered product, saturated to the grid
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!dpos_q[a]) begin
        idx[a] = '0;
      end else if (|prod_q[a][2*CW-1:CW+AXIS_BITS]) begin
        idx[a] = AXIS_MAX;
      end else begin
        idx[a] = prod_q[a][CW+AXIS_BITS-1:CW];
      end
    end
    cell_d = {idx[2], idx[1], idx[0]};
  end

  // read data split and accumulate update
  always_comb begin
    cnt_rd = ram_rdata[COUNT_BITS-1:0];
    for (int a = 0; a < 3; a++) begin
      sum_rd[a] = ram_rdata[WORD_W-1-a*SUM_W -: SUM_W];
      mag[a]    = sum_rd[a][SUM_W-1] ? SUM_W'(-sum_rd[a]) : sum_rd[a];
      divd[a]   = {1'b0, mag[a]} + DIVD_W'(cnt_rd >> 1);
    end
  end

  always_comb begin
    ram_re    = (state_q == vcs_pkg::S_IDX);
    ram_we    = 1'b0;
    ram_waddr = cell_q;
    ram_wdata = ram_rdata;
    if (state_q == vcs_pkg::S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == vcs_pkg::S_RD && !in_q.op && cnt_rd != COUNT_MAX) begin
      ram_we = 1'b1;
      for (int a = 0; a < 3; a++) begin
        ram_wdata[WORD_W-1-a*SUM_W -: SUM_W] =
          sum_rd[a] + {{(SUM_W-CW){coord[a][CW-1]}}, coord[a]};
      end
      ram_wdata[COUNT_BITS-1:0] = cnt_rd + COUNT_BITS'(1);
    end
  end

  vcs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NCELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_d),
    .rdata_o (ram_rdata)
  );

  assign div_start = (state_q == vcs_pkg::S_RD) && in_q.op && (cnt_rd != '0);

  for (genvar g = 0; g < 3; g++) begin : g_div
    vcs_divider #(
      .DIVIDEND_W (DIVD_W),
      .DIVISOR_W  (COUNT_BITS)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (divd[g]),
      .divisor_i  (cnt_rd),
      .done_o     (div_done[g]),
      .quotient_o (quo[g])
    );
  end

  // repeat removal and ring closing
  logic          first_v, emit, close;
  logic [CW-1:0] new_last [3];
  logic [CW-1:0] new_ring [3];

  always_comb begin
    first_v = in_q.poly_first || !ring_open_q;
    emit    = first_v || rep_q[0] != last_q[0] || rep_q[1] != last_q[1] ||
              rep_q[2] != last_q[2];
    for (int a = 0; a < 3; a++) begin
      new_last[a] = emit ? rep_q[a] : last_q[a];
      new_ring[a] = first_v ? rep_q[a] : ring_q[a];
    end
    close = in_q.poly_last && (new_last[0] != new_ring[0] ||
            new_last[1] != new_ring[1] || new_last[2] != new_ring[2]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vcs_pkg::S_CLEAR: if (clr_q == CELL_W'(NCELLS - 1)) state_d = vcs_pkg::S_IDLE;
      vcs_pkg::S_IDLE:  if (start) state_d = vcs_pkg::S_MUL;
      vcs_pkg::S_MUL:   state_d = vcs_pkg::S_IDX;
      vcs_pkg::S_IDX:   state_d = vcs_pkg::S_RD;
      vcs_pkg::S_RD: begin
        if (!in_q.op) state_d = vcs_pkg::S_IDLE;
        else if (cnt_rd == '0) state_d = vcs_pkg::S_OUT;
        else state_d = vcs_pkg::S_DIV;
      end
      vcs_pkg::S_DIV:   if (&div_done) state_d = vcs_pkg::S_OUT;
      vcs_pkg::S_OUT:   state_d = (emit && close) ? vcs_pkg::S_CLOSE : vcs_pkg::S_IDLE;
      vcs_pkg::S_CLOSE: state_d = vcs_pkg::S_IDLE;
      default:          state_d = vcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vcs_pkg::S_CLEAR;
      clr_q       <= '0;
      res_vld_q   <= 1'b0;
      ring_open_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        last_q[a] <= '0;
        ring_q[a] <= '0;
      end
    end else begin
      state_q   <= state_d;
      res_vld_q <= 1'b0;
      if (state_q == vcs_pkg::S_CLEAR) begin
        clr_q <= clr_q + CELL_W'(1);
      end
      if (state_q == vcs_pkg::S_OUT) begin
        res_vld_q   <= emit || close;
        ring_open_q <= !in_q.poly_last;
        for (int a = 0; a < 3; a++) begin
          ring_q[a] <= new_ring[a];
          last_q[a] <= close ? new_ring[a] : new_last[a];
        end
      end
      if (state_q == vcs_pkg::S_CLOSE) begin
        res_vld_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == vcs_pkg::S_IDLE && start) begin
      in_q <= item_i;
    end
    if (state_q == vcs_pkg::S_MUL) begin
      for (int a = 0; a < 3; a++) begin
        logic [CW:0] d;
        d         = {coord[a][CW-1], coord[a]} - {gmin_q[a][CW-1], gmin_q[a]};
        dpos_q[a] <= !d[CW] && (d != '0);
        prod_q[a] <= d[CW-1:0] * scale_q[a];
      end
    end
    if (state_q == vcs_pkg::S_IDX) begin
      cell_q <= cell_d;
    end
    if (state_q == vcs_pkg::S_RD) begin
      missing_q <= (cnt_rd == '0);
      for (int a = 0; a < 3; a++) begin
        neg_q[a] <= sum_rd[a][SUM_W-1];
        rep_q[a] <= '0;
      end
    end
    if (state_q == vcs_pkg::S_DIV && (&div_done)) begin
      for (int a = 0; a < 3; a++) begin
        rep_q[a] <= neg_q[a] ? CW'(-quo[a][CW-1:0]) : quo[a][CW-1:0];
      end
    end
    if (state_q == vcs_pkg::S_OUT) begin
      if (emit) begin
        res_q.rep_x        <= rep_q[0];
        res_q.rep_y        <= rep_q[1];
        res_q.rep_z        <= rep_q[2];
        res_q.interior_out <= in_q.interior_in;
        res_q.polygon_end  <= in_q.poly_last && !close;
        res_q.run_last     <= !close;
        res_q.cell_missing <= missing_q;
      end else begin
        res_q.rep_x        <= new_ring[0];
        res_q.rep_y        <= new_ring[1];
        res_q.rep_z        <= new_ring[2];
        res_q.interior_out <= 1'b0;
        res_q.polygon_end  <= 1'b1;
        res_q.run_last     <= 1'b1;
        res_q.cell_missing <= 1'b0;
      end
    end
    if (state_q == vcs_pkg::S_CLOSE) begin
      res_q.rep_x        <= ring_q[0];
      res_q.rep_y        <= ring_q[1];
      res_q.rep_z        <= ring_q[2];
      res_q.interior_out <= 1'b0;
      res_q.polygon_end  <= 1'b1;
      res_q.run_last     <= 1'b1;
      res_q.cell_missing <= 1'b0;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  `VCS_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `VCS_ASSERT(a_first_then_close, clk_i, rst_ni,
              (result_valid_o && !result_o.run_last) |=> (result_valid_o && result_o.run_last))
  `VCS_ASSERT(a_no_write_on_map, clk_i, rst_ni,
              (ram_we && state_q != vcs_pkg::S_CLEAR) |-> !in_q.op)

endmodule
